/* design/bsd_pkg.sv */
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies; imported by every module of the block.
package bsd_pkg;

  localparam int COORD_W = 12;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PIX  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_PLANES   = 3'd1,
    ERR_BPP      = 3'd2,
    ERR_COMPRESS = 3'd3,
    ERR_CLR_USED = 3'd4,
    ERR_CLR_IMP  = 3'd5,
    ERR_TRUNC    = 3'd6,
    ERR_SIZE     = 3'd7
  } err_t;

  // index of the header byte that completes each checked field
  localparam logic [5:0] HDR_WIDTH_LAST    = 6'd21;
  localparam logic [5:0] HDR_HEIGHT_LAST   = 6'd25;
  localparam logic [5:0] HDR_PLANES_LAST   = 6'd27;
  localparam logic [5:0] HDR_BPP_LAST      = 6'd29;
  localparam logic [5:0] HDR_COMPRESS_LAST = 6'd33;
  localparam logic [5:0] HDR_CLR_USED_LAST = 6'd49;
  localparam logic [5:0] HDR_CLR_IMP_LAST  = 6'd53;

  localparam logic [15:0] REQ_PLANES = 16'd1;
  localparam logic [15:0] REQ_BPP    = 16'd24;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    kind_t               kind;
    err_t                error_code;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [COORD_W-1:0]  pixel_row;
    logic [COORD_W-1:0]  pixel_column;
  } out_t;

  // one queued event: an optional pixel followed by an optional done/error
  typedef struct packed {
    logic                pix_vld;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                tail_vld;
    kind_t               tail_kind;
    err_t                tail_code;
  } ev_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* design/bsd_front.sv */
// Front end: parses header bytes, walks pixel rows and builds events.
// Depends on bsd_pkg.
module bsd_front import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic acc,
  input  in_t  in_data,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output logic push,
  output ev_t  ev
);

  // at least two bits so the pad count can be taken from the width
  localparam int WW = ($clog2(MAX_WIDTH + 1) < 2) ? 2 : $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {
    PH_HDR   = 2'd0,
    PH_PIX   = 2'd1,
    PH_DRAIN = 2'd2
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [5:0]     hcnt_r, hcnt_nxt;
  logic [31:0]    fs_r, fs_nxt;
  logic [WW-1:0]  width_r, width_nxt;
  logic [HW-1:0]  height_r, height_nxt;
  logic [HW-1:0]  row_r, row_nxt;
  logic [WW-1:0]  col_r, col_nxt;
  logic [1:0]     bip_r, bip_nxt;
  logic [1:0]     pad_r, pad_nxt;
  logic [7:0]     blue_r, blue_nxt;
  logic [7:0]     green_r, green_nxt;
  logic           flip_r;

  logic [HW-1:0]  row_inc;
  logic [WW-1:0]  col_inc;
  logic [HW-1:0]  out_row;
  logic [1:0]     pad_dec;
  logic           do_end_row;

  assign row_inc = row_r + 1'b1;
  assign col_inc = col_r + 1'b1;
  assign out_row = flip_r ? row_r : (height_r - 1'b1 - row_r);
  assign pad_dec = (pad_r == 2'd0) ? 2'd0 : pad_r - 2'd1;

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    fs_nxt     = fs_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    bip_nxt    = bip_r;
    pad_nxt    = pad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    do_end_row = 1'b0;
    ev         = '0;
    ev.tail_kind = KIND_DONE;
    ev.tail_code = ERR_NONE;

    if (acc) begin
      unique case (phase_r)
        PH_HDR: begin
          hcnt_nxt = hcnt_r + 6'd1;
          fs_nxt   = {in_data.byte_value, fs_r[31:8]};
          unique case (hcnt_r)
            HDR_WIDTH_LAST: begin
              if (fs_nxt[31] || (fs_nxt > 32'(MAX_WIDTH))) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_SIZE;
                phase_nxt   = PH_DRAIN;
              end else begin
                width_nxt = fs_nxt[WW-1:0];
              end
            end
            HDR_HEIGHT_LAST: begin
              if (fs_nxt[31] || (fs_nxt > 32'(MAX_HEIGHT))) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_SIZE;
                phase_nxt   = PH_DRAIN;
              end else begin
                height_nxt = fs_nxt[HW-1:0];
              end
            end
            HDR_PLANES_LAST: begin
              if (fs_nxt[31:16] != REQ_PLANES) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_PLANES;
                phase_nxt   = PH_DRAIN;
              end
            end
            HDR_BPP_LAST: begin
              if (fs_nxt[31:16] != REQ_BPP) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_BPP;
                phase_nxt   = PH_DRAIN;
              end
            end
            HDR_COMPRESS_LAST: begin
              if (fs_nxt != 32'd0) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_COMPRESS;
                phase_nxt   = PH_DRAIN;
              end
            end
            HDR_CLR_USED_LAST: begin
              if (fs_nxt != 32'd0) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_CLR_USED;
                phase_nxt   = PH_DRAIN;
              end
            end
            HDR_CLR_IMP_LAST: begin
              if (fs_nxt != 32'd0) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_CLR_IMP;
                phase_nxt   = PH_DRAIN;
              end else if (width_r == '0 || height_r == '0) begin
                ev.tail_vld = 1'b1; ev.tail_kind = KIND_DONE;
                phase_nxt   = PH_DRAIN;
              end else begin
                phase_nxt = PH_PIX;
                row_nxt   = '0;
                col_nxt   = '0;
                bip_nxt   = 2'd0;
                pad_nxt   = 2'd0;
              end
            end
            default: ;
          endcase
        end
        PH_PIX: begin
          if (col_r < width_r) begin
            if (bip_r == 2'd0) begin
              blue_nxt = in_data.byte_value;
              bip_nxt  = 2'd1;
            end else if (bip_r == 2'd1) begin
              green_nxt = in_data.byte_value;
              bip_nxt   = 2'd2;
            end else begin
              ev.pix_vld = 1'b1;
              ev.red     = in_data.byte_value;
              ev.green   = green_r;
              ev.blue    = blue_r;
              ev.row     = COORD_W'(out_row);
              ev.col     = COORD_W'(col_r);
              bip_nxt    = 2'd0;
              col_nxt    = col_inc;
              if (col_inc >= width_r) begin
                pad_nxt = width_r[1:0];
                if (width_r[1:0] == 2'd0) do_end_row = 1'b1;
              end
            end
          end else begin
            pad_nxt = pad_dec;
            if (pad_dec == 2'd0) do_end_row = 1'b1;
          end
          if (do_end_row) begin
            row_nxt = row_inc;
            col_nxt = '0;
            bip_nxt = 2'd0;
            if (row_inc >= height_r) begin
              ev.tail_vld = 1'b1; ev.tail_kind = KIND_DONE;
              phase_nxt   = PH_DRAIN;
            end
          end
        end
        default: ;  // drain: ignore bytes until end of file
      endcase

      if (in_data.end_of_file) begin
        if (phase_nxt != PH_DRAIN) begin
          ev.tail_vld = 1'b1; ev.tail_kind = KIND_ERR; ev.tail_code = ERR_TRUNC;
        end
        phase_nxt = PH_HDR;
        hcnt_nxt  = 6'd0;
        fs_nxt    = 32'd0;
        row_nxt   = '0;
        col_nxt   = '0;
        bip_nxt   = 2'd0;
        pad_nxt   = 2'd0;
      end
    end
  end

  assign push = acc && (ev.pix_vld || ev.tail_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      hcnt_r   <= 6'd0;
      fs_r     <= 32'd0;
      width_r  <= '0;
      height_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      bip_r    <= 2'd0;
      pad_r    <= 2'd0;
      blue_r   <= 8'd0;
      green_r  <= 8'd0;
      flip_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      fs_r     <= fs_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      bip_r    <= bip_nxt;
      pad_r    <= pad_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      if (cfg_we) flip_r <= cfg_wdata;
    end
  end

endmodule

/* design/bsd_fifo.sv */
// Short event queue between front end and back end.
// Depends on bsd_pkg.
module bsd_fifo import bsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ev_t     push_ev,
  input  logic    pop,
  output ev_t     head_ev,
  output q_stat_t stat
);

  ev_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head_ev    = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* design/bsd_back.sv */
// Back end: splits queued events into result beats behind an output register.
// Depends on bsd_pkg.
module bsd_back import bsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  ev_t     head_ev,
  input  q_stat_t stat,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic half_r, half_nxt;   // pixel of a two-beat event already sent
  logic load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    half_nxt      = half_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !stat.empty;
      if (!stat.empty) begin
        out_nxt = '0;
        if (head_ev.pix_vld && !half_r) begin
          out_nxt.kind         = KIND_PIX;
          out_nxt.error_code   = ERR_NONE;
          out_nxt.red          = head_ev.red;
          out_nxt.green        = head_ev.green;
          out_nxt.blue         = head_ev.blue;
          out_nxt.pixel_row    = head_ev.row;
          out_nxt.pixel_column = head_ev.col;
          if (head_ev.tail_vld) half_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          out_nxt.kind       = head_ev.tail_kind;
          out_nxt.error_code = head_ev.tail_code;
          half_nxt           = 1'b0;
          pop                = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/bmp24_stream_decoder.sv */
// Top level of the 24-bit BMP stream decoder: front end, event queue, back end.
// Depends on bsd_pkg, bsd_front, bsd_fifo, bsd_back.
//
//  port group   dir  handshake          payload
//  in_*         in   in_valid/in_ready  in_data (in_t: byte_value, end_of_file)
//  out_*        out  out_valid/out_ready out_data (out_t: kind, code, RGB, row, col)
//  cfg_*        in   cfg_we             cfg_wdata (flip_rows)
//
// One byte is taken per cycle while the four-entry event queue has room; a
// byte's result goes through the event queue and then the output register to out_data.
// A byte that ends both a pixel and the image yields two beats, one per cycle while out_ready is high.
// Synchronous active-low reset; no clearing pass. in_ready falls only when
// the queue is full, so a stalled output side backs up into the input.
module bmp24_stream_decoder import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic    acc;
  logic    q_push;
  logic    q_pop;
  ev_t     push_ev;
  ev_t     head_ev;
  q_stat_t q_stat;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  bsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (q_push),
    .ev        (push_ev)
  );

  bsd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ev (push_ev),
    .pop     (q_pop),
    .head_ev (head_ev),
    .stat    (q_stat)
  );

  bsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_ev   (head_ev),
    .stat      (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("event pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("event popped from empty queue");

  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_ERR) |-> out_data.error_code == ERR_NONE)
    else $error("error code on non-error beat");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_PIX) |->
      (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0 &&
       out_data.pixel_row == '0 && out_data.pixel_column == '0))
    else $error("pixel fields set on status beat");
`endif

endmodule

/* tb/bsd_pixel_monitor.sv */
// Result monitor for the 24-bit BMP stream decoder: follows every accepted byte beat,
// predicts the pixel, done and error beats it yields and compares them with the output.
// Depends on bsd_pkg.
module bsd_pixel_monitor import bsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] WIDTH_LIMIT  = 32'd4096;
  localparam logic [31:0] HEIGHT_LIMIT = 32'd4096;
  localparam int          REPORT_CAP   = 50;

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_PIXELS = 2'd1,
    ST_DRAIN  = 2'd2
  } stage_t;

  stage_t      stage;
  logic [5:0]  hdr_idx;
  logic [31:0] hdr_shift;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [12:0] row_cnt;
  logic [12:0] col_cnt;
  logic [1:0]  byte_sel;
  logic [1:0]  pad_left;
  logic [7:0]  held_b;
  logic [7:0]  held_g;
  logic        flip;

  out_t decoded_beats[$];
  int   bad_beats = 0;

  task automatic push_result(input kind_t k, input err_t c, input logic [7:0] r, g, b,
                             input logic [11:0] row, col);
    out_t beat;
    beat.kind         = k;
    beat.error_code   = c;
    beat.red          = r;
    beat.green        = g;
    beat.blue         = b;
    beat.pixel_row    = row;
    beat.pixel_column = col;
    decoded_beats.push_back(beat);
  endtask

  task automatic reject(input err_t c);
    push_result(KIND_ERR, c, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    stage = ST_DRAIN;
  endtask

  task automatic restart();
    stage     = ST_HEADER;
    hdr_idx   = '0;
    hdr_shift = '0;
    row_cnt   = '0;
    col_cnt   = '0;
    byte_sel  = '0;
    pad_left  = '0;
  endtask

  task automatic next_row();
    row_cnt  = row_cnt + 13'd1;
    col_cnt  = '0;
    byte_sel = '0;
    if (row_cnt >= img_h) begin
      push_result(KIND_DONE, ERR_NONE, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
      stage = ST_DRAIN;
    end
  endtask

  function automatic bit oversize(input logic [31:0] v, input logic [31:0] limit);
    return v[31] || (v > limit);
  endfunction

  task automatic decode_byte(input in_t beat);
    logic [5:0]  idx;
    logic [12:0] orow;
    if (stage == ST_HEADER) begin
      idx       = hdr_idx;
      hdr_idx   = hdr_idx + 6'd1;
      hdr_shift = {beat.byte_value, hdr_shift[31:8]};
      case (idx)
        HDR_WIDTH_LAST: begin
          if (oversize(hdr_shift, WIDTH_LIMIT)) reject(ERR_SIZE);
          else img_w = hdr_shift[12:0];
        end
        HDR_HEIGHT_LAST: begin
          if (oversize(hdr_shift, HEIGHT_LIMIT)) reject(ERR_SIZE);
          else img_h = hdr_shift[12:0];
        end
        HDR_PLANES_LAST: begin
          if (hdr_shift[31:16] != REQ_PLANES) reject(ERR_PLANES);
        end
        HDR_BPP_LAST: begin
          if (hdr_shift[31:16] != REQ_BPP) reject(ERR_BPP);
        end
        HDR_COMPRESS_LAST: begin
          if (hdr_shift != 0) reject(ERR_COMPRESS);
        end
        HDR_CLR_USED_LAST: begin
          if (hdr_shift != 0) reject(ERR_CLR_USED);
        end
        HDR_CLR_IMP_LAST: begin
          if (hdr_shift != 0) begin
            reject(ERR_CLR_IMP);
          end else if (img_w == 0 || img_h == 0) begin
            // empty image: done right on the last header byte
            push_result(KIND_DONE, ERR_NONE, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
            stage = ST_DRAIN;
          end else begin
            stage    = ST_PIXELS;
            row_cnt  = '0;
            col_cnt  = '0;
            byte_sel = '0;
            pad_left = '0;
          end
        end
        default: ;
      endcase
    end else if (stage == ST_PIXELS) begin
      if (col_cnt < img_w) begin
        case (byte_sel)
          2'd0: begin
            held_b   = beat.byte_value;
            byte_sel = 2'd1;
          end
          2'd1: begin
            held_g   = beat.byte_value;
            byte_sel = 2'd2;
          end
          default: begin
            orow = flip ? row_cnt : img_h - 13'd1 - row_cnt;
            push_result(KIND_PIX, ERR_NONE, beat.byte_value, held_g, held_b,
                        orow[11:0], col_cnt[11:0]);
            byte_sel = 2'd0;
            col_cnt  = col_cnt + 13'd1;
            if (col_cnt >= img_w) begin
              // row padding is width mod 4 bytes for 24-bit pixels
              pad_left = img_w[1:0];
              if (pad_left == 0) next_row();
            end
          end
        endcase
      end else begin
        if (pad_left > 0) pad_left = pad_left - 2'd1;
        if (pad_left == 0) next_row();
      end
    end
    if (beat.end_of_file) begin
      if (stage == ST_HEADER || stage == ST_PIXELS)
        push_result(KIND_ERR, ERR_TRUNC, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
      restart();
    end
  endtask

  function automatic int field_diff(input string name, input logic [31:0] want,
                                    input logic [31:0] got, input bit loud);
    if (got !== want) begin
      if (loud) $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    int   diffs;
    bit   loud;
    if (!rst_n) begin
      flip   = 1'b0;
      img_w  = '0;
      img_h  = '0;
      held_b = '0;
      held_g = '0;
      restart();
      decoded_beats.delete();
    end else begin
      if (cfg_we) flip = cfg_wdata;
      if (in_valid && in_ready) decode_byte(in_data);
      if (out_valid && out_ready) begin
        loud = bad_beats < REPORT_CAP;
        if (decoded_beats.size() == 0) begin
          if (loud) $error("result beat with none pending: kind %0d", out_data.kind);
          bad_beats++;
        end else begin
          want  = decoded_beats.pop_front();
          diffs = field_diff("kind", want.kind, out_data.kind, loud)
                + field_diff("error_code", want.error_code, out_data.error_code, loud)
                + field_diff("red", want.red, out_data.red, loud)
                + field_diff("green", want.green, out_data.green, loud)
                + field_diff("blue", want.blue, out_data.blue, loud)
                + field_diff("pixel_row", want.pixel_row, out_data.pixel_row, loud)
                + field_diff("pixel_column", want.pixel_column, out_data.pixel_column,
                             loud);
          if (diffs != 0) bad_beats++;
        end
      end
    end
    mismatches  <= bad_beats;
    outstanding <= decoded_beats.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the BMP stream decoder bench: clock, reset, file stimulus, output stalls,
// flip register writes and the verdict. Depends on bsd_pkg, bmp24_stream_decoder
// and bsd_pixel_monitor.
module testbench import bsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int HOLD_CYCLES      = 150;
  localparam int SETTLE_CYCLES    = 16;
  localparam int BEATS_PER_PHASE  = 40;

  typedef enum int {
    END_CLEAN,
    END_TRAILING,
    END_CUT
  } ending_t;

  typedef enum int {
    HF_WIDTH,
    HF_HEIGHT,
    HF_PLANES,
    HF_BPP,
    HF_COMPRESS,
    HF_CLR_USED,
    HF_CLR_IMP
  } hdr_field_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   mismatches;
  int   outstanding;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  beats_sent     = 0;
  int  cycles         = 0;
  in_t file_q[$];

  bmp24_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bsd_pixel_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: random stalls, or one long hold-off when asked
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    file_q.push_back(in_t'{b, 1'b0});
  endtask

  task automatic add_field(input int nbytes, input logic [31:0] v);
    for (int i = 0; i < nbytes; i++) add_byte(v[8*i +: 8]);
  endtask

  // 54-byte header; fields the block does not check get random content
  task automatic add_header(input logic [31:0] w, h, planes, bpp, comp, used, imp);
    add_field(2, $urandom());
    add_field(4, $urandom());
    add_field(4, $urandom());
    add_field(4, $urandom());
    add_field(4, $urandom());
    add_field(4, w);
    add_field(4, h);
    add_field(2, planes);
    add_field(2, bpp);
    add_field(4, comp);
    add_field(4, $urandom());
    add_field(4, $urandom());
    add_field(4, $urandom());
    add_field(4, used);
    add_field(4, imp);
  endtask

  function automatic int field_end(input hdr_field_t which);
    case (which)
      HF_WIDTH:    return int'(HDR_WIDTH_LAST);
      HF_HEIGHT:   return int'(HDR_HEIGHT_LAST);
      HF_PLANES:   return int'(HDR_PLANES_LAST);
      HF_BPP:      return int'(HDR_BPP_LAST);
      HF_COMPRESS: return int'(HDR_COMPRESS_LAST);
      HF_CLR_USED: return int'(HDR_CLR_USED_LAST);
      default:     return int'(HDR_CLR_IMP_LAST);
    endcase
  endfunction

  task automatic send_file();
    in_t last;
    last = file_q.pop_back();
    last.end_of_file = 1'b1;
    file_q.push_back(last);
    foreach (file_q[i]) send_beat(file_q[i]);
    file_q.delete();
  endtask

  task automatic send_image(input int w, h, input ending_t ending, input int cut);
    int len;
    add_header(w, h, 1, 24, 0, 0, 0);
    for (int r = 0; r < h; r++)
      for (int i = 0; i < 3 * w + (w & 3); i++) add_byte($urandom_range(255));
    case (ending)
      END_TRAILING: repeat ($urandom_range(8, 1)) add_byte($urandom_range(255));
      END_CUT: begin
        len = (cut > 0) ? cut : $urandom_range(file_q.size() - 1, 1);
        while (file_q.size() > len) void'(file_q.pop_back());
      end
      default: ;
    endcase
    send_file();
  endtask

  task automatic send_bad_header(input hdr_field_t which, input logic [31:0] bad);
    logic [31:0] f[7];
    int          len;
    f = '{32'd3, 32'd2, 32'd1, 32'd24, 32'd0, 32'd0, 32'd0};
    f[which] = bad;
    add_header(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
    // everything after the failing field is drained, so only a few bytes follow it
    len = field_end(which) + 1 + int'($urandom_range(3));
    while (file_q.size() > len) void'(file_q.pop_back());
    send_file();
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // trailing bytes may still be in flight without any result
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_flip(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int idle, stall, input logic flip, input bit squeeze);
    int         start;
    int         pick;
    int         w;
    int         h;
    int         r;
    hdr_field_t which;
    logic [31:0] bad;
    quiesce();
    write_flip(flip);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = beats_sent;
    if (squeeze) begin
      hold_req = 1'b1;
      // pixel-dense image while the output is held, so the queue fills up
      send_image(6, 2, END_CLEAN, 0);
    end
    while (beats_sent - start < BEATS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        h = ($urandom_range(11) == 0) ? 0 : $urandom_range(4, 1);
        r = $urandom_range(19);
        send_image(w, h, (r < 2) ? END_CUT : (r < 4) ? END_TRAILING : END_CLEAN, 0);
      end else if (pick < 85) begin
        which = hdr_field_t'($urandom_range(HF_CLR_IMP));
        case (which)
          HF_WIDTH, HF_HEIGHT:
            bad = $urandom_range(1) ? ($urandom() | 32'h8000_0000)
                                    : $urandom_range(65535, 4097);
          HF_PLANES: begin
            bad = $urandom_range(65535);
            if (bad == 1) bad = 0;
          end
          HF_BPP: begin
            bad = $urandom_range(65535);
            if (bad == 24) bad = 0;
          end
          default: bad = $urandom() | (32'd1 << $urandom_range(31));
        endcase
        send_bad_header(which, bad);
      end else begin
        // noise: random bytes with an occasional early end of file
        repeat ($urandom_range(80, 1))
          file_q.push_back(in_t'{8'($urandom_range(255)), $urandom_range(29) == 0});
        send_file();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_flip(1'b1);

    // pixel bytes at both extremes, width 2 so two pad bytes follow
    add_header(2, 1, 1, 24, 0, 0, 0);
    add_byte(8'hff); add_byte(8'h00); add_byte(8'hff);
    add_byte(8'h00); add_byte(8'hff); add_byte(8'h00);
    add_byte(8'hff); add_byte(8'h00);
    send_file();
    send_image(4, 1, END_CLEAN, 0);    // last byte ends a pixel and the image
    send_image(2, 0, END_CLEAN, 0);    // done on the final header byte, which is also eof
    send_bad_header(HF_WIDTH, 32'd4097);
    send_bad_header(HF_HEIGHT, 32'hffff_fff0);
    send_bad_header(HF_PLANES, 32'd2);
    send_bad_header(HF_BPP, 32'd32);
    send_bad_header(HF_COMPRESS, 32'd1);
    send_bad_header(HF_CLR_USED, 32'd256);
    send_bad_header(HF_CLR_IMP, 32'd1);
    send_image(2, 2, END_CUT, 10);     // eof inside the header
    send_image(2, 2, END_CUT, 57);     // eof on a byte that completes a pixel
    send_image(2, 2, END_CUT, 1);      // one-byte file
    send_image(1, 2, END_CUT, 58);     // eof on a pad byte

    quiesce();
    write_flip(1'b0);
    // largest width and height both pass; two pixels of the bottom-up first row
    add_header(4096, 4096, 1, 24, 0, 0, 0);
    repeat (6) add_byte($urandom_range(255));
    send_file();

    random_phase(0, 0, 1'b0, 1'b1);
    random_phase(56, 0, 1'b1, 1'b0);
    random_phase(0, 56, 1'b0, 1'b0);
    random_phase(23, 23, 1'b1, 1'b0);

    quiesce();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
